[rtl/ftsm_pkg.sv]
// ----------------------------------------------------------------------------
// ftsm_pkg
// Shared types and constants of the frame time smoother: request and result
// payloads, widths of the ring, the statistics and the shared divider.
// ----------------------------------------------------------------------------
package ftsm_pkg;

    // Ring geometry and field widths
    localparam int DEPTH      = 30;
    localparam int TICK_W     = 32;
    localparam int FPS_W      = 18;
    localparam int RATE_W     = 16;
    localparam int GAME_W     = TICK_W + RATE_W - 8;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH);
    localparam int SUM_W      = TICK_W + $clog2(DEPTH);
    localparam int ACC_W      = 34;
    localparam int FRAMES_W   = 16;
    localparam int FPSSUM_W   = FPS_W + FRAMES_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Shared divider: dividend wide enough for either sum, divisor for either count
    localparam int DIV_NW = (SUM_W > FPSSUM_W) ? SUM_W : FPSSUM_W;
    localparam int DIV_DW = (FRAMES_W > CNT_W) ? FRAMES_W : CNT_W;
    localparam int DIV_CW = $clog2(DIV_NW + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GAME_RATE        = 1'b1;

    // Register reset values
    localparam logic [TICK_W-1:0] TPS_RESET  = TICK_W'(10000000);
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(256);

    // Request commands
    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [TICK_W-1:0] elapsed_ticks;
        logic [FPS_W-1:0]  fps_sample;
    } t_in;

    typedef struct packed {
        logic [TICK_W-1:0] smoothed_ticks;
        logic [GAME_W-1:0] game_ticks;
        logic [FPS_W-1:0]  average_fps;
        logic [FPS_W-1:0]  worst_fps;
    } t_out;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_NW-1:0] quotient;
    } t_div_rsp;

endpackage

[rtl/ftsm_ram.sv]
// ----------------------------------------------------------------------------
// ftsm_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module ftsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ftsm_div.sv]
// ----------------------------------------------------------------------------
// ftsm_div
// Iterative restoring divider, one quotient bit per cycle. Shared by the ring
// mean and the per-second FPS mean. Divisor must be non-zero.
// ----------------------------------------------------------------------------
module ftsm_div
    import ftsm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_NW-1:0] r_num;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_DW-1:0] r_rem;

    logic [DIV_DW:0]   shifted;
    logic [DIV_DW:0]   diff;
    logic              qbit;

    always_comb begin
        shifted = {r_rem, r_num[DIV_NW-1]};
        diff    = shifted - {1'b0, r_den};
        qbit    = (shifted >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift the quotient into the dividend register
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.dividend;
            r_den <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_NW-2:0], qbit};
            r_rem <= qbit ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_num;

endmodule

[rtl/frame_time_smoother_fps_stats_core.sv]
// ----------------------------------------------------------------------------
// frame_time_smoother_fps_stats_core
// Frame time smoother with per-second FPS mean, worst FPS and game delta.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one request per
//   frame: cmd frame update with elapsed ticks and FPS sample, or cmd clear
//   statistics. Every request yields exactly one result on the output channel
//   (o_out_valid / i_out_stall / o_out_data).
//   Configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_index
//   (0 ticks per second, 1 game rate Q8.8); write only while idle.
//   A clear goes from the accepting edge through the game delta state to the
//   output register; a frame update also runs the shared bit-serial divider
//   for the ring mean once the ring holds more than 15 deltas, and again for
//   the FPS mean when a second rolls over with frames counted. One request
//   is in flight at a time and the next is taken in the cycle after the
//   result is registered.
//   The deltas sit in a 30-entry RAM with registered read data: the oldest
//   entry is read while the new delta is written, in the accept cycle.
//   Reset clears the ring count, sum and statistics; the RAM is not cleared,
//   as an entry is only read after it has been written.
//   When the receiver stalls, the result is held in the output register and
//   the next request is still accepted and worked; it waits for the output
//   register to free before it is published.
// ----------------------------------------------------------------------------
module frame_time_smoother_fps_stats_core
    import ftsm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out                  o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_DV1  = 3'd2;
    localparam logic [2:0] ST_ACC  = 3'd3;
    localparam logic [2:0] ST_DV2  = 3'd4;
    localparam logic [2:0] ST_MUL  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    localparam logic [IDX_W-1:0]    LAST_IDX   = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]    FULL_CNT   = CNT_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]    HALF_CNT   = CNT_W'(DEPTH / 2);
    localparam logic [ACC_W-1:0]    ACC_MAX    = '1;
    localparam logic [FRAMES_W-1:0] FRAMES_MAX = '1;

    logic [2:0]          r_state,  n_state;
    logic [TICK_W-1:0]   r_dt;
    logic [FPS_W-1:0]    r_fps;
    logic [IDX_W-1:0]    r_widx,   n_widx;
    logic [CNT_W-1:0]    r_count,  n_count;
    logic [SUM_W-1:0]    r_sum,    n_sum;
    logic [TICK_W-1:0]   r_smooth, n_smooth;
    logic [ACC_W-1:0]    r_accum,  n_accum;
    logic [FRAMES_W-1:0] r_frames, n_frames;
    logic [FPSSUM_W-1:0] r_fpssum, n_fpssum;
    logic [FPS_W-1:0]    r_mean,   n_mean;
    logic [FPS_W-1:0]    r_lowest, n_lowest;
    logic [TICK_W-1:0]   r_tps;
    logic [RATE_W-1:0]   r_rate;
    logic [GAME_W-1:0]   r_game;
    logic                r_out_valid;
    t_out                r_out_data;

    logic                in_accept;
    logic                out_free;
    logic [IDX_W-1:0]    next_idx;
    logic [TICK_W-1:0]   ram_rdata;
    t_div_req            div_req;
    t_div_rsp            div_rsp;

    logic [ACC_W:0]      acc_raw;
    logic [ACC_W-1:0]    acc_sat;
    logic [ACC_W-1:0]    sec;
    logic                wrap;
    logic [FRAMES_W-1:0] frames_base;
    logic [FPSSUM_W-1:0] fpssum_base;
    logic [TICK_W+RATE_W-1:0] product;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign next_idx  = (r_widx == LAST_IDX) ? '0 : r_widx + 1'b1;

    // Write the new delta and read the oldest one in the accept cycle
    ftsm_ram #(
        .WIDTH(TICK_W),
        .DEPTH(DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (in_accept && i_in_data.cmd == CMD_FRAME),
        .i_waddr(r_widx),
        .i_wdata(i_in_data.elapsed_ticks),
        .i_raddr(next_idx),
        .o_rdata(ram_rdata)
    );

    ftsm_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    // One-second accumulator arithmetic for the accumulate state, and the game delta product
    always_comb begin
        sec         = (r_tps == '0) ? ACC_W'(1) : ACC_W'(r_tps);
        acc_raw     = {1'b0, r_accum} + (ACC_W + 1)'(r_smooth);
        acc_sat     = acc_raw[ACC_W] ? ACC_MAX : acc_raw[ACC_W-1:0];
        wrap        = (acc_sat > sec);
        frames_base = wrap ? '0 : r_frames;
        fpssum_base = wrap ? '0 : r_fpssum;
        product     = r_smooth * r_rate;
    end

    always_comb begin
        n_state  = r_state;
        n_widx   = r_widx;
        n_count  = r_count;
        n_sum    = r_sum;
        n_smooth = r_smooth;
        n_accum  = r_accum;
        n_frames = r_frames;
        n_fpssum = r_fpssum;
        n_mean   = r_mean;
        n_lowest = r_lowest;
        div_req  = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    if (i_in_data.cmd == CMD_CLEAR) begin
                        // Clear statistics; keep the ring and smoothed delta
                        n_mean   = '0;
                        n_accum  = '0;
                        n_fpssum = '0;
                        n_frames = '0;
                        n_lowest = '1;
                        n_state  = ST_MUL;
                    end else begin
                        n_widx  = next_idx;
                        n_state = ST_RD;
                    end
                end
            end
            ST_RD: begin
                // Add the new delta, drop the oldest once the ring is full
                if (r_count == FULL_CNT) begin
                    n_sum = r_sum + SUM_W'(r_dt) - SUM_W'(ram_rdata);
                end else begin
                    n_sum   = r_sum + SUM_W'(r_dt);
                    n_count = r_count + 1'b1;
                end
                if (n_count > HALF_CNT) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_NW'(n_sum);
                    div_req.divisor  = DIV_DW'(n_count);
                    n_state          = ST_DV1;
                end else begin
                    n_smooth = r_dt;
                    n_state  = ST_ACC;
                end
            end
            ST_DV1: begin
                if (div_rsp.done) begin
                    n_smooth = div_rsp.quotient[TICK_W-1:0];
                    n_state  = ST_ACC;
                end
            end
            ST_ACC: begin
                n_state = ST_MUL;
                if (wrap) begin
                    n_accum = acc_sat - sec;
                    if (r_frames != '0) begin
                        // Divider latches the old sum and count before they clear
                        div_req.start    = 1'b1;
                        div_req.dividend = DIV_NW'(r_fpssum);
                        div_req.divisor  = DIV_DW'(r_frames);
                        n_state          = ST_DV2;
                    end else begin
                        n_mean = '0;
                    end
                end else begin
                    n_accum = acc_sat;
                end
                n_frames = frames_base;
                n_fpssum = fpssum_base;
                if (frames_base != FRAMES_MAX) begin
                    n_frames = frames_base + 1'b1;
                    n_fpssum = fpssum_base + FPSSUM_W'(r_fps);
                end
                if (r_lowest > r_fps) begin
                    n_lowest = r_fps;
                end
            end
            ST_DV2: begin
                if (div_rsp.done) begin
                    n_mean  = div_rsp.quotient[FPS_W-1:0];
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                // Hold until the output register is free
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_widx      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_smooth    <= '0;
            r_accum     <= '0;
            r_frames    <= '0;
            r_fpssum    <= '0;
            r_mean      <= '0;
            r_lowest    <= '1;
            r_tps       <= TPS_RESET;
            r_rate      <= RATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_widx   <= n_widx;
            r_count  <= n_count;
            r_sum    <= n_sum;
            r_smooth <= n_smooth;
            r_accum  <= n_accum;
            r_frames <= n_frames;
            r_fpssum <= n_fpssum;
            r_mean   <= n_mean;
            r_lowest <= n_lowest;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_TICKS_PER_SECOND: r_tps  <= i_cfg_wdata[TICK_W-1:0];
                    REG_GAME_RATE:        r_rate <= i_cfg_wdata[RATE_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: latched request, game delta, published result
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_dt  <= i_in_data.elapsed_ticks;
            r_fps <= i_in_data.fps_sample;
        end
        if (r_state == ST_MUL) begin
            r_game <= product[TICK_W+RATE_W-1:8];
        end
        if (r_state == ST_OUT && out_free) begin
            r_out_data.smoothed_ticks <= r_smooth;
            r_out_data.game_ticks     <= r_game;
            r_out_data.average_fps    <= r_mean;
            r_out_data.worst_fps      <= r_lowest;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
